@@ rtl/random_aligned_offset_gen_top_assert.svh @@
// Assertion macros for the random aligned offset generator.
`ifndef RANDOM_ALIGNED_OFFSET_GEN_TOP_ASSERT_SVH
`define RANDOM_ALIGNED_OFFSET_GEN_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define RAOG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("raog: same-cycle check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define RAOG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("raog: next-cycle check failed");
`else
`define RAOG_ASSERT_IMPL(lbl, ante, cons)
`define RAOG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/raog_pkg.sv @@
// Shared constants for the random aligned offset generator.
package raog_pkg;

  // Field and datapath widths
  localparam int SEED_W  = 64;
  localparam int FILE_W  = 48;
  localparam int READ_W  = 31;
  localparam int ALIGN_W = 32;
  localparam int OFF_W   = 48;
  localparam int RAW_W   = 64;
  localparam int MUL_W   = 64;
  localparam int HALF_W  = MUL_W / 2;
  localparam int ACC_W   = 2 * MUL_W;

  // Default offset width
  localparam int OFFSET_BITS_DEF = 48;

  // SplitMix64 constants
  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX2   = 64'h94d049bb133111eb;
  localparam int SH1 = 30;
  localparam int SH2 = 27;
  localparam int SH3 = 31;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READ  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN = 2'd3;

  // Register reset values
  localparam logic [FILE_W-1:0]  FILE_RST  = 48'd67108864;
  localparam logic [READ_W-1:0]  READ_RST  = 31'd4096;
  localparam logic [ALIGN_W-1:0] ALIGN_RST = 32'd1;

endpackage

@@ rtl/raog_mac.sv @@
// Shared 32x32 multiplier with a 128-bit accumulator for 64x64 products.
module raog_mac import raog_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MUL_W-1:0] a,
  input  logic [MUL_W-1:0] b,
  output logic [ACC_W-1:0] acc,
  output logic             done
);

  logic [2:0]          cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                pv_r, pv_nxt;
  logic                done_r, done_nxt;
  logic [MUL_W-1:0]    prod_r, prod_nxt;
  logic [1:0]          psh_r, psh_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [HALF_W-1:0]   a_part, b_part;

  // Partial product select: al*bl, al*bh, ah*bl, ah*bh
  assign a_part = cnt_r[1] ? a[MUL_W-1:HALF_W] : a[HALF_W-1:0];
  assign b_part = cnt_r[0] ? b[MUL_W-1:HALF_W] : b[HALF_W-1:0];

  // Sequencer and accumulate
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    pv_nxt   = 1'b0;
    done_nxt = 1'b0;
    prod_nxt = prod_r;
    psh_nxt  = psh_r;
    acc_nxt  = acc_r;
    if (pv_r) begin
      acc_nxt = acc_r + ({{MUL_W{1'b0}}, prod_r} << {psh_r, 5'b0});
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == 3'd4) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        prod_nxt = {{HALF_W{1'b0}}, a_part} * {{HALF_W{1'b0}}, b_part};
        psh_nxt  = {1'b0, cnt_r[1]} + {1'b0, cnt_r[0]};
        pv_nxt   = 1'b1;
        cnt_nxt  = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      pv_r   <= pv_nxt;
      done_r <= done_nxt;
    end
    prod_r <= prod_nxt;
    psh_r  <= psh_nxt;
    acc_r  <= acc_nxt;
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

@@ rtl/raog_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module raog_div import raog_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [OFF_W-1:0]   dividend,
  input  logic [ALIGN_W-1:0] divisor,
  output logic [OFF_W-1:0]   quotient,
  output logic               done
);

  localparam int CNT_W = $clog2(OFF_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(OFF_W - 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [ALIGN_W-1:0] rem_r, rem_nxt;
  logic [OFF_W-1:0]   quo_r, quo_nxt;
  logic [ALIGN_W:0]   trial;
  logic               fits;

  // Trial subtract of the shifted remainder
  assign trial = {rem_r, quo_r[OFF_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? ALIGN_W'(trial - {1'b0, divisor}) : trial[ALIGN_W-1:0];
      quo_nxt = {quo_r[OFF_W-2:0], fits};
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

@@ rtl/random_aligned_offset_gen_top.sv @@
// Top level of the random aligned offset generator: registers, sequencer, output stage.
//
//   channel | direction | handshake             | payload
//   in      | in        | in_valid / in_ready   | in_restart
//   out     | out       | out_valid / out_ready | out_offset, out_raw_value, out_drew
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A request with no room to move goes straight to S_DONE without a draw. Each multiply runs
// on the shared 32x32 multiplier (four partial products); an aligned draw also runs the
// 48-step serial divider.
// Synchronous reset; no clearing pass. in_ready is high only between requests.
// A finished result waits in the output register while the next request is accepted;
// the next result then holds in S_DONE until the output register is taken.
`include "random_aligned_offset_gen_top_assert.svh"
module random_aligned_offset_gen_top import raog_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OFF_W-1:0]     out_offset,
  output logic [RAW_W-1:0]     out_raw_value,
  output logic                 out_drew,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SEED_W-1:0]    cfg_data
);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_XOR  = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_MUL3 = 4'd5;
  localparam logic [3:0] S_MUL4 = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  logic [3:0]         state_r, state_nxt;
  logic [SEED_W-1:0]  seed_r, seed_nxt;
  logic [FILE_W-1:0]  file_r, file_nxt;
  logic [READ_W-1:0]  read_r, read_nxt;
  logic [ALIGN_W-1:0] align_r, align_nxt;
  logic [63:0]        rng_r, rng_nxt;
  logic [63:0]        z_r, z_nxt;
  logic [OFF_W-1:0]   max_r, max_nxt;
  logic [MUL_W-1:0]   a_r, a_nxt;
  logic [MUL_W-1:0]   b_r, b_nxt;
  logic               mgo_r, mgo_nxt;
  logic               dgo_r, dgo_nxt;
  logic [RAW_W-1:0]   raw_r, raw_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic               drew_r, drew_nxt;
  logic               ov_r, ov_nxt;
  logic [OFF_W-1:0]   oo_r, oo_nxt;
  logic [RAW_W-1:0]   or_r, or_nxt;
  logic               od_r, od_nxt;

  logic [ACC_W-1:0]   acc;
  logic               mac_done;
  logic [OFF_W-1:0]   quo;
  logic               div_done;
  logic [63:0]        base;
  logic [63:0]        lo;
  logic [63:0]        hi;
  logic               room;
  logic               align_en;
  logic [OFF_W-1:0]   off_mask;

  // Shared multiplier
  raog_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mgo_r),
    .a     (a_r),
    .b     (b_r),
    .acc   (acc),
    .done  (mac_done)
  );

  // Slot count divider
  raog_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dgo_r),
    .dividend (max_r),
    .divisor  (align_r),
    .quotient (quo),
    .done     (div_done)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign lo        = acc[63:0];
  assign hi        = acc[ACC_W-1:64];
  assign room      = file_r > {{(FILE_W-READ_W){1'b0}}, read_r};
  assign align_en  = align_r > 32'd1;
  assign base      = in_restart ? ((seed_r == '0) ? GOLDEN : seed_r) : rng_r;

  // Offset width mask
  always_comb begin
    for (int i = 0; i < OFF_W; i++) begin
      off_mask[i] = (i < OFFSET_BITS);
    end
  end

  // Configuration writes
  always_comb begin
    seed_nxt  = seed_r;
    file_nxt  = file_r;
    read_nxt  = read_r;
    align_nxt = align_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEED:  seed_nxt  = cfg_data;
        REG_FILE:  file_nxt  = cfg_data[FILE_W-1:0];
        REG_READ:  read_nxt  = cfg_data[READ_W-1:0];
        REG_ALIGN: align_nxt = cfg_data[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    rng_nxt   = rng_r;
    z_nxt     = z_r;
    max_nxt   = max_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    mgo_nxt   = 1'b0;
    dgo_nxt   = 1'b0;
    raw_nxt   = raw_r;
    off_nxt   = off_r;
    drew_nxt  = drew_r;
    ov_nxt    = ov_r;
    oo_nxt    = oo_r;
    or_nxt    = or_r;
    od_nxt    = od_r;
    if (out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          max_nxt = file_r - {{(FILE_W-READ_W){1'b0}}, read_r};
          if (room) begin
            rng_nxt   = base + GOLDEN;
            z_nxt     = base + GOLDEN;
            drew_nxt  = 1'b1;
            state_nxt = S_XOR;
          end else begin
            rng_nxt   = base;
            raw_nxt   = '0;
            off_nxt   = '0;
            drew_nxt  = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end
      S_XOR: begin
        a_nxt     = z_r ^ (z_r >> SH1);
        b_nxt     = MIX1;
        mgo_nxt   = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        if (mac_done) begin
          a_nxt     = lo ^ (lo >> SH2);
          b_nxt     = MIX2;
          mgo_nxt   = 1'b1;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mac_done) begin
          raw_nxt = lo ^ (lo >> SH3);
          a_nxt   = lo ^ (lo >> SH3);
          if (align_en) begin
            dgo_nxt   = 1'b1;
            state_nxt = S_DIV;
          end else begin
            b_nxt     = {{(MUL_W-OFF_W){1'b0}}, max_r} + 64'd1;
            mgo_nxt   = 1'b1;
            state_nxt = S_MUL3;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          b_nxt     = {{(MUL_W-OFF_W){1'b0}}, quo} + 64'd1;
          mgo_nxt   = 1'b1;
          state_nxt = S_MUL3;
        end
      end
      S_MUL3: begin
        if (mac_done) begin
          if (align_en) begin
            a_nxt     = hi;
            b_nxt     = {{(MUL_W-ALIGN_W){1'b0}}, align_r};
            mgo_nxt   = 1'b1;
            state_nxt = S_MUL4;
          end else begin
            off_nxt   = hi[OFF_W-1:0];
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL4: begin
        if (mac_done) begin
          off_nxt   = lo[OFF_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          oo_nxt    = off_r & off_mask;
          or_nxt    = raw_r;
          od_nxt    = drew_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seed_r  <= '0;
      file_r  <= FILE_RST;
      read_r  <= READ_RST;
      align_r <= ALIGN_RST;
      rng_r   <= GOLDEN;
      mgo_r   <= 1'b0;
      dgo_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      seed_r  <= seed_nxt;
      file_r  <= file_nxt;
      read_r  <= read_nxt;
      align_r <= align_nxt;
      rng_r   <= rng_nxt;
      mgo_r   <= mgo_nxt;
      dgo_r   <= dgo_nxt;
      ov_r    <= ov_nxt;
    end
    z_r    <= z_nxt;
    max_r  <= max_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    raw_r  <= raw_nxt;
    off_r  <= off_nxt;
    drew_r <= drew_nxt;
    oo_r   <= oo_nxt;
    or_r   <= or_nxt;
    od_r   <= od_nxt;
  end

  assign out_valid     = ov_r;
  assign out_offset    = oo_r;
  assign out_raw_value = or_r;
  assign out_drew      = od_r;

  // Checks
  `RAOG_ASSERT_IMPL(a_nodraw_raw, out_valid && !out_drew, out_raw_value == '0)
  `RAOG_ASSERT_IMPL(a_nodraw_off, out_valid && !out_drew, out_offset == '0)
  `RAOG_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  `RAOG_ASSERT_IMPL(a_one_unit, mac_done, !div_done)

endmodule
